[design/vsi_pkg.sv]
// Package for the value sorter: payload structs, controller states, command
// and status structs, and the key mapping used by the compare logic.
// No dependencies.
package vsi_pkg;

  localparam int DefMaxItems = 64;
  localparam int KeyW        = 64;
  localparam int OrigW       = 7;

  typedef struct packed {
    logic [KeyW-1:0] key_bits;
    logic            is_last;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0]  sorted_key;
    logic [OrigW-1:0] origin_index;
    logic             overflowed;
    logic             last_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_OUT
  } vsi_state_t;

  typedef struct packed {
    logic load;   // store the incoming key
    logic close;  // the set is closed; sample the sort direction
    logic start;  // begin a scan for the next result
    logic emit;   // the current result was taken
  } vsi_cmd_t;

  typedef struct packed {
    logic done;   // scan finished, result register loaded
    logic last;   // the loaded result is the final one of the set
  } vsi_status_t;

  // Maps a double bit pattern to an unsigned value in numeric order.
  function automatic logic [KeyW-1:0] order_key(input logic [KeyW-1:0] bits);
    logic [KeyW-1:0] b;
    b = bits;
    if (b == {1'b1, {(KeyW-1){1'b0}}}) begin
      b = '0;
    end
    if (b[KeyW-1]) begin
      return ~b;
    end
    return b | {1'b1, {(KeyW-1){1'b0}}};
  endfunction

endpackage

[design/vsi_chan_if.sv]
// Valid/ready channel carrying one payload struct per transaction.
// Depends on nothing; the payload type is a parameter.
interface vsi_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/vsi_ctrl.sv]
// Controller state machine of the value sorter.
// Depends on vsi_pkg.
module vsi_ctrl
  import vsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  vsi_status_t status,
  output vsi_cmd_t    cmd
);

  vsi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          cmd.close = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = status.last ? ST_LOAD : ST_START;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

[design/vsi_dpath.sv]
// Datapath of the value sorter: key memory, fill count, and the scan unit
// that finds the next key in (key, position) order. Depends on vsi_pkg.
module vsi_dpath
  import vsi_pkg::*;
#(
  parameter int MaxItems = DefMaxItems
)(
  input  logic            clk,
  input  logic            rst_n,
  input  vsi_cmd_t        cmd,
  input  logic [KeyW-1:0] in_key,
  input  logic            cfg_desc,
  output vsi_status_t     status,
  output out_item_t       out_data
);

  localparam int IW = $clog2(MaxItems);
  localparam int CW = $clog2(MaxItems + 1);

  logic [KeyW-1:0] key_mem [MaxItems];

  logic [CW-1:0]   count_r;
  logic            ovf_r;
  logic            desc_r;
  logic [CW-1:0]   issue_r;
  logic            issuing_r;
  logic            busy_r;
  logic            rd_pend_r;
  logic [IW-1:0]   rd_idx_r;
  logic [KeyW-1:0] rd_key_r;
  logic            found_r;
  logic [KeyW-1:0] best_sk_r;
  logic [KeyW-1:0] best_raw_r;
  logic [IW-1:0]   best_p_r;
  logic            have_prev_r;
  logic [KeyW-1:0] prev_sk_r;
  logic [IW-1:0]   prev_p_r;
  logic [CW-1:0]   emit_cnt_r;
  out_item_t       out_r;

  logic            full;
  logic [KeyW-1:0] cand_sk;
  logic            above_prev;
  logic            below_best;
  logic            scan_done;

  assign full = (count_r == CW'(MaxItems));

  // Descending order is ascending order of the complemented key; the
  // position stays ascending so equal keys keep load order either way.
  assign cand_sk    = desc_r ? ~order_key(rd_key_r) : order_key(rd_key_r);
  assign above_prev = !have_prev_r || ({cand_sk, rd_idx_r} > {prev_sk_r, prev_p_r});
  assign below_best = !found_r || ({cand_sk, rd_idx_r} < {best_sk_r, best_p_r});
  assign scan_done  = busy_r && !issuing_r && !rd_pend_r;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      key_mem[count_r[IW-1:0]] <= in_key;
    end
    rd_key_r <= key_mem[issue_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      desc_r      <= 1'b0;
      issue_r     <= '0;
      issuing_r   <= 1'b0;
      busy_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      emit_cnt_r  <= '0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.close) begin
        desc_r <= cfg_desc;
      end
      rd_pend_r <= issuing_r;
      rd_idx_r  <= issue_r[IW-1:0];
      if (cmd.start) begin
        issue_r   <= '0;
        issuing_r <= 1'b1;
        busy_r    <= 1'b1;
        found_r   <= 1'b0;
      end else if (issuing_r) begin
        issue_r <= issue_r + 1'b1;
        if (issue_r + 1'b1 == count_r) begin
          issuing_r <= 1'b0;
        end
      end
      if (rd_pend_r && above_prev && below_best) begin
        found_r    <= 1'b1;
        best_sk_r  <= cand_sk;
        best_raw_r <= rd_key_r;
        best_p_r   <= rd_idx_r;
      end
      if (scan_done) begin
        busy_r              <= 1'b0;
        out_r.sorted_key    <= best_raw_r;
        out_r.origin_index  <= OrigW'({1'b0, best_p_r} + 1'b1);
        out_r.overflowed    <= ovf_r;
        out_r.last_out      <= (emit_cnt_r + 1'b1 == count_r);
      end
      if (cmd.emit) begin
        prev_sk_r   <= best_sk_r;
        prev_p_r    <= best_p_r;
        // The final result of a set empties the block for the next set.
        have_prev_r <= !out_r.last_out;
        emit_cnt_r  <= out_r.last_out ? '0 : emit_cnt_r + 1'b1;
        if (out_r.last_out) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
      end
    end
  end

  assign status.done = scan_done;
  assign status.last = out_r.last_out;
  assign out_data    = out_r;

endmodule

[design/value_sorter_with_indices.sv]
// Top level of the value sorter: stable argsort of up to MaxItems doubles.
// Depends on vsi_pkg, vsi_chan_if, vsi_ctrl and vsi_dpath.
//
//   channel   direction  payload                                     handshake
//   in_chan   in         key_bits, is_last                           valid/ready
//   out_chan  out        sorted_key, origin_index, overflowed, last  valid/ready
//   cfg_*     in         cfg_wdata = descending                      cfg_we
//
// Keys load one per cycle while a set is open. After the closing key, one
// full pass over the key memory's single read port picks each next result.
// Reset is synchronous and active low; it empties the set and clears the
// direction. The input stalls while results are produced, and a stalled
// result holds in the output register until taken.
module value_sorter_with_indices
  import vsi_pkg::*;
#(
  parameter int MaxItems = DefMaxItems
)(
  input  logic       clk,
  input  logic       rst_n,
  vsi_chan_if.sink   in_chan,
  vsi_chan_if.source out_chan,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic        cfg_desc_r;
  vsi_cmd_t    cmd;
  vsi_status_t status;
  in_item_t    in_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_desc_r <= 1'b0;
    end else if (cfg_we) begin
      cfg_desc_r <= cfg_wdata;
    end
  end

  assign in_item = in_chan.data;

  vsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_item.is_last),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vsi_dpath #(.MaxItems(MaxItems)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_key   (in_item.key_bits),
    .cfg_desc (cfg_desc_r),
    .status   (status),
    .out_data (out_chan.data)
  );

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input ready while a result is offered");

  // A closing transaction stops further input until the set drains.
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_item.is_last) |=> !in_chan.ready)
    else $error("input accepted right after closing a set");

  // Taking the final result reopens the input.
  a_drain_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.data.last_out) |=> in_chan.ready)
    else $error("input not ready after the final result");

endmodule

[sim/value_sorter_with_indices_tb.sv]
// Testbench for value_sorter_with_indices: drives sets of doubles through the
// valid/ready channels and checks every sorted result against a stable argsort.
// Depends on vsi_pkg, vsi_chan_if and the design top level.
module value_sorter_with_indices_tb;
  import vsi_pkg::*;

  localparam int Cap = DefMaxItems;
  localparam int CycleLimit = 4000000;
  localparam int NumDirected = 20;
  // The single key sent right after reset comes back as the only result.
  localparam out_item_t FirstWant = {64'h3FF0_0000_0000_0000, 7'd1, 1'b0, 1'b1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  vsi_chan_if #(.T(in_item_t)) in_chan ();
  vsi_chan_if #(.T(out_item_t)) out_chan ();

  value_sorter_with_indices u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: keys of the open set and the sort direction.
  logic [63:0] set_keys[$];
  logic        set_overflow;
  logic        sort_desc;
  out_item_t   sorted_queue[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  n_results = 0;
  bit  quiet = 1'b0;
  bit  stall_on = 1'b1;

  function automatic logic [63:0] numeric_rank(logic [63:0] b);
    if (b == 64'h8000_0000_0000_0000) b = '0;
    return b[63] ? ~b : (b | 64'h8000_0000_0000_0000);
  endfunction

  // Stable insertion sort; emits results into sorted_queue.
  task automatic sort_and_queue();
    int idx[$];
    int j;
    int cur;
    out_item_t r;
    for (int i = 0; i < set_keys.size(); i++) begin
      j = idx.size();
      idx.push_back(i);
      while (j > 0 && (sort_desc ?
             numeric_rank(set_keys[i]) > numeric_rank(set_keys[idx[j-1]]) :
             numeric_rank(set_keys[i]) < numeric_rank(set_keys[idx[j-1]]))) begin
        idx[j] = idx[j-1];
        j--;
      end
      idx[j] = i;
    end
    for (int i = 0; i < idx.size(); i++) begin
      cur = idx[i];
      r.sorted_key = set_keys[cur];
      r.origin_index = OrigW'(cur + 1);
      r.overflowed = set_overflow;
      r.last_out = (i == idx.size() - 1);
      sorted_queue.push_back(r);
    end
    set_keys.delete();
    set_overflow = 1'b0;
  endtask

  task automatic predict_load(in_item_t it);
    if (set_keys.size() < Cap) set_keys.push_back(it.key_bits);
    else set_overflow = 1'b1;
    if (it.is_last) sort_and_queue();
  endtask

  // Sink side: random stall bursts and result checking.
  int sink_hold = 0;
  out_item_t got;
  out_item_t want;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (sorted_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result key=%h", got.sorted_key);
        end else begin
          want = sorted_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: exp key=%h idx=%0d ovf=%b last=%b,",
                        " got key=%h idx=%0d ovf=%b last=%b"},
                       want.sorted_key, want.origin_index, want.overflowed, want.last_out,
                       got.sorted_key, got.origin_index, got.overflowed, got.last_out);
          end
        end
        if (n_results == 0 && got !== FirstWant) begin
          mismatches++;
          if (mismatches <= 10)
            $display("First result: exp key=%h idx=%0d last=%b, got key=%h idx=%0d last=%b",
                     FirstWant.sorted_key, FirstWant.origin_index, FirstWant.last_out,
                     got.sorted_key, got.origin_index, got.last_out);
        end
        n_results++;
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_chan.ready <= 1'b0;
      end else if (stall_on && !quiet && $urandom_range(0, 19) == 0) begin
        sink_hold <= $urandom_range(1, 13) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one transaction; a random gap burst may precede it.
  task automatic send_key(logic [63:0] k, logic lst);
    in_item_t it;
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.key_bits = k;
    it.is_last = lst;
    in_chan.valid <= 1'b1;
    in_chan.data <= it;
    do @(posedge clk); while (!in_chan.ready);
    predict_load(it);
  endtask

  task automatic idle_and_drain();
    in_chan.valid <= 1'b0;
    while (sorted_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_dir(logic d);
    idle_and_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sort_desc = d;
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = {$urandom_range(0, 1) == 1, 63'h0};
      1: v = {$urandom_range(0, 1) == 1, 11'h7FF, 52'h0};
      2: v = {$urandom_range(0, 1) == 1, 11'($urandom_range(1020, 1030)), 52'h0};
      3: v = {$urandom_range(0, 1) == 1, 63'($urandom_range(0, 3))};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Directed rows: key, last flag.
  logic [63:0] dir_key[NumDirected] = '{
    64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
    64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 64'h7FF8_0000_0000_0000,
    64'hFFF8_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h4000_0000_0000_0000,
    64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000};
  bit dir_last[NumDirected] = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,1, 1, 0,1};

  int n;
  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    set_overflow = 1'b0;
    sort_desc = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single key right after reset: known result at a glance.
    send_key(64'h3FF0_0000_0000_0000, 1'b1);
    for (int i = 0; i < NumDirected; i++) send_key(dir_key[i], dir_last[i]);
    write_dir(1'b1);
    for (int i = 0; i < NumDirected; i++) send_key(dir_key[i], dir_last[i]);
    // Overflow: a full set plus dropped keys, last one dropped too.
    for (int i = 0; i < Cap + 2; i++) send_key(rand_double(), i == Cap + 1);
    write_dir(1'b0);
    for (int i = 0; i < Cap + 1; i++) send_key(rand_double(), i == Cap);

    // Random sets, mostly small; the direction changes between phases.
    for (int ph = 0; ph < 6; ph++) begin
      write_dir(ph[0]);
      if (ph == 5) quiet = 1'b1;
      for (int s = 0; s < 2; s++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_key(rand_double(), i == n - 1);
      end
    end
    idle_and_drain();
    if (mismatches == 0 && sorted_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
